FILE: design/pli_pkg.sv
// Shared types and constants for the particle leapfrog integrator.
// Payload structs, configuration register indexes and pipeline sideband bundles.
// No dependencies.
package pli_pkg;

	typedef logic signed [31:0] fx_t;
	typedef logic [2:0][31:0] vec3_t;

	typedef struct packed {
		fx_t pos_x;
		fx_t pos_y;
		fx_t pos_z;
		fx_t vel_x;
		fx_t vel_y;
		fx_t vel_z;
		fx_t force_x;
		fx_t force_y;
		fx_t force_z;
		fx_t corr_x;
		fx_t corr_y;
		fx_t corr_z;
	} pli_in_t;

	typedef struct packed {
		fx_t new_pos_x;
		fx_t new_pos_y;
		fx_t new_pos_z;
		fx_t new_vel_x;
		fx_t new_vel_y;
		fx_t new_vel_z;
		fx_t mid_vel_x;
		fx_t mid_vel_y;
		fx_t mid_vel_z;
	} pli_out_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_TIME_STEP   = 3'd0;
	localparam cfg_idx_t REG_SIM_SCALE   = 3'd1;
	localparam cfg_idx_t REG_FORCE_LIMIT = 3'd2;
	localparam cfg_idx_t REG_GRAVITY_Z   = 3'd3;
	localparam cfg_idx_t REG_SMOOTHING   = 3'd4;

	// Item carried alongside the magnitude root and the force clamp divide
	typedef struct packed {
		vec3_t pos;
		vec3_t vel;
		vec3_t frc;
		vec3_t corr;
		logic  clamp;
	} pli_frc_t;

	// Item carried alongside the position divide
	typedef struct packed {
		vec3_t      pos;
		vec3_t      vel;
		vec3_t      vn;
		logic [2:0] neg;
	} pli_pos_t;

endpackage

FILE: design/pli_sqrt.sv
// Pipelined integer square root of a 64-bit radicand, one result bit per stage.
// Carries an opaque sideband word alongside. Depends on nothing.
module pli_sqrt #(
	parameter int unsigned SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [63:0]       rad,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_vld,
	output logic [31:0]       root,
	output logic [SIDE_W-1:0] side_out
);
	localparam int unsigned STAGES = 32;

	logic              vld  [STAGES+1];
	logic [33:0]       rem  [STAGES+1];
	logic [31:0]       rt   [STAGES+1];
	logic [63:0]       rest [STAGES+1];
	logic [SIDE_W-1:0] sd   [STAGES+1];

	assign vld[0]  = in_vld;
	assign rem[0]  = '0;
	assign rt[0]   = '0;
	assign rest[0] = rad;
	assign sd[0]   = side_in;

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [35:0] t;
		logic [35:0] trial;
		logic        ge;
		logic [35:0] r;

		// bring in two radicand bits and try the next root bit
		always_comb begin
			t     = {rem[k], rest[k][63:62]};
			trial = {2'b00, rt[k], 2'b01};
			ge    = (t >= trial);
			r     = ge ? (t - trial) : t;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else if (en) begin
				vld[k+1] <= vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem[k+1]  <= r[33:0];
				rt[k+1]   <= {rt[k][30:0], ge};
				rest[k+1] <= {rest[k][61:0], 2'b00};
				sd[k+1]   <= sd[k];
			end
		end
	end

	assign out_vld  = vld[STAGES];
	assign root     = rt[STAGES];
	assign side_out = sd[STAGES];

endmodule

FILE: design/pli_div3.sv
// Pipelined restoring divider, three numerators over one shared divisor.
// One quotient bit per stage; the numerator must be below divisor * 2^Q_W.
// Carries an opaque sideband word alongside. Depends on nothing.
module pli_div3 #(
	parameter int unsigned DEN_W  = 32,
	parameter int unsigned Q_W    = 31,
	parameter int unsigned SIDE_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [2:0][DEN_W+Q_W-1:0]   num,
	input  logic [DEN_W-1:0]            den,
	input  logic [SIDE_W-1:0]           side_in,
	output logic                        out_vld,
	output logic [2:0][Q_W-1:0]         quo,
	output logic [SIDE_W-1:0]           side_out
);
	localparam int unsigned ACC_W = DEN_W + Q_W;

	logic                   vld [Q_W+1];
	logic [2:0][ACC_W-1:0]  acc [Q_W+1];
	logic [DEN_W-1:0]       dv  [Q_W+1];
	logic [SIDE_W-1:0]      sd  [Q_W+1];

	assign vld[0] = in_vld;
	assign acc[0] = num;
	assign dv[0]  = den;
	assign sd[0]  = side_in;

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [2:0][ACC_W-1:0] nxt;

		// shift in one numerator bit per lane, subtract where it fits
		always_comb begin
			for (int l = 0; l < 3; l++) begin
				logic [DEN_W:0] t;
				logic           ge;
				logic [DEN_W:0] r;
				t      = acc[k][l][ACC_W-1:Q_W-1];
				ge     = (t >= {1'b0, dv[k]});
				r      = ge ? (t - {1'b0, dv[k]}) : t;
				nxt[l] = {r[DEN_W-1:0], acc[k][l][Q_W-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else if (en) begin
				vld[k+1] <= vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc[k+1] <= nxt;
				dv[k+1]  <= dv[k];
				sd[k+1]  <= sd[k];
			end
		end
	end

	assign out_vld = vld[Q_W];
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			quo[l] = acc[Q_W][l][Q_W-1:0];
		end
	end
	assign side_out = sd[Q_W];

endmodule

FILE: design/particle_leapfrog_integrator.sv
// Accepts one particle per cycle whenever no finished result waits to be taken.
// Depth is set by the 32-stage magnitude root, the 31-stage force clamp divide
// and the 48-stage position divide, plus ten arithmetic stages, the first of which
// captures the input transfer.
// The whole pipeline holds while a finished result waits to be taken.
// Reset clears all valid bits and loads the default register values.
// Top level: pli_pkg, pli_sqrt, pli_div3.
module particle_leapfrog_integrator #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  pli_pkg::pli_in_t         in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output pli_pkg::pli_out_t        out_data,
	input  logic                     cfg_wr_en,
	input  pli_pkg::cfg_idx_t        cfg_index,
	input  logic [pli_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import pli_pkg::*;

	localparam longint unsigned ONE     = 64'd1 << FRAC_BITS;
	localparam longint unsigned LIM_RAW = 64'd600 * ONE;
	localparam logic [16:0] TS_RST  = 17'((ONE + 64'd500) / 64'd1000);
	localparam logic [30:0] SS_RST  = 31'(ONE);
	localparam logic [30:0] LIM_RST = 31'((LIM_RAW > 64'h7FFFFFFF) ? 64'h7FFFFFFF : LIM_RAW);
	localparam logic [31:0] GZ_RST  = 32'(64'd0 - ((64'd98 * ONE + 64'd5) / 64'd10));
	localparam logic [16:0] SF_RST  = 17'((ONE + 64'd5) / 64'd10);

	function automatic logic [31:0] sat_fx(input logic signed [51:0] v);
		if (v > 52'sd2147483647) begin
			return 32'h7FFFFFFF;
		end else if (v < -52'sd2147483648) begin
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

	// configuration registers
	logic [16:0] time_step_q;
	logic [30:0] sim_scale_q;
	logic [30:0] force_limit_q;
	logic [31:0] gravity_z_q;
	logic [16:0] smoothing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q   <= TS_RST;
			sim_scale_q   <= SS_RST;
			force_limit_q <= LIM_RST;
			gravity_z_q   <= GZ_RST;
			smoothing_q   <= SF_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_TIME_STEP:   time_step_q   <= cfg_wdata[16:0];
				REG_SIM_SCALE:   sim_scale_q   <= cfg_wdata[30:0];
				REG_FORCE_LIMIT: force_limit_q <= cfg_wdata[30:0];
				REG_GRAVITY_Z:   gravity_z_q   <= cfg_wdata;
				REG_SMOOTHING:   smoothing_q   <= cfg_wdata[16:0];
				default: ;
			endcase
		end
	end

	// global advance: hold everything while the result waits
	logic en;
	logic vld_s10;
	assign en       = !vld_s10 || out_ready;
	assign in_ready = en;

	// stage 1: capture item, add gravity to force z
	logic  vld_s1;
	vec3_t p_s1, v_s1, f_s1, c_s1;
	logic signed [51:0] fz_sum;
	assign fz_sum = 52'(in_data.force_z) + 52'($signed(gravity_z_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= {in_data.pos_z, in_data.pos_y, in_data.pos_x};
			v_s1 <= {in_data.vel_z, in_data.vel_y, in_data.vel_x};
			f_s1 <= {sat_fx(fz_sum), in_data.force_y, in_data.force_x};
			c_s1 <= {in_data.corr_z, in_data.corr_y, in_data.corr_x};
		end
	end

	// stage 2: squares of force components and of the limit
	logic             vld_s2;
	vec3_t            p_s2, v_s2, f_s2, c_s2;
	logic [2:0][63:0] sq_s2;
	logic [61:0]      lim2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= p_s1;
			v_s2 <= v_s1;
			f_s2 <= f_s1;
			c_s2 <= c_s1;
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= {32'd0, mag32(f_s1[i])} * {32'd0, mag32(f_s1[i])};
			end
			lim2_s2 <= {31'd0, force_limit_q} * {31'd0, force_limit_q};
		end
	end

	// stage 3: squared magnitude and clamp decision
	logic        vld_s3;
	pli_frc_t    frc_s3;
	logic [63:0] m2_s3;
	logic [63:0] m2_sum;
	assign m2_sum = sq_s2[0] + sq_s2[1] + sq_s2[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			frc_s3.pos   <= p_s2;
			frc_s3.vel   <= v_s2;
			frc_s3.frc   <= f_s2;
			frc_s3.corr  <= c_s2;
			frc_s3.clamp <= (m2_sum > {2'b00, lim2_s2});
			m2_s3        <= m2_sum;
		end
	end

	// magnitude root
	logic        sq_vld;
	logic [31:0] root;
	pli_frc_t    frc_sq;

	pli_sqrt #(
		.SIDE_W ($bits(pli_frc_t))
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.rad      (m2_s3),
		.side_in  (frc_s3),
		.out_vld  (sq_vld),
		.root     (root),
		.side_out (frc_sq)
	);

	// stage 4: scaled magnitudes for the clamp divide
	logic             vld_s4;
	pli_frc_t         frc_s4;
	logic [2:0][62:0] num_s4;
	logic [31:0]      den_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			frc_s4 <= frc_sq;
			for (int i = 0; i < 3; i++) begin
				num_s4[i] <= {31'd0, mag32(frc_sq.frc[i])} * {32'd0, force_limit_q};
			end
			den_s4 <= (root == 32'd0) ? 32'd1 : root;
		end
	end

	logic             fd_vld;
	logic [2:0][30:0] fq;
	pli_frc_t         frc_fd;

	pli_div3 #(
		.DEN_W  (32),
		.Q_W    (31),
		.SIDE_W ($bits(pli_frc_t))
	) u_frc_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.num      (num_s4),
		.den      (den_s4),
		.side_in  (frc_s4),
		.out_vld  (fd_vld),
		.quo      (fq),
		.side_out (frc_fd)
	);

	// stage 5: clamped force with sign restored
	logic  vld_s5;
	logic  clamp_s5;
	vec3_t p_s5, v_s5, c_s5, fc_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= fd_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s5     <= frc_fd.pos;
			v_s5     <= frc_fd.vel;
			c_s5     <= frc_fd.corr;
			clamp_s5 <= frc_fd.clamp;
			for (int i = 0; i < 3; i++) begin
				if (!frc_fd.clamp) begin
					fc_s5[i] <= frc_fd.frc[i];
				end else if (frc_fd.frc[i][31]) begin
					fc_s5[i] <= 32'd0 - {1'b0, fq[i]};
				end else begin
					fc_s5[i] <= {1'b0, fq[i]};
				end
			end
		end
	end

	// stage 6: velocity increments, floored
	logic             vld_s6;
	vec3_t            p_s6, v_s6;
	logic [2:0][49:0] dv_s6, dc_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s6 <= p_s5;
			v_s6 <= v_s5;
			for (int i = 0; i < 3; i++) begin
				logic signed [49:0] pf;
				logic signed [49:0] pc;
				pf = $signed({1'b0, time_step_q}) * $signed(fc_s5[i]);
				pc = $signed({1'b0, smoothing_q}) * $signed(c_s5[i]);
				dv_s6[i] <= pf >>> FRAC_BITS;
				dc_s6[i] <= pc >>> FRAC_BITS;
			end
		end
	end

	// stage 7: new velocity, saturated
	logic  vld_s7;
	vec3_t p_s7, v_s7, vn_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s7 <= p_s6;
			v_s7 <= v_s6;
			for (int i = 0; i < 3; i++) begin
				vn_s7[i] <= sat_fx(52'($signed(v_s6[i])) + 52'($signed(dv_s6[i]))
					+ 52'($signed(dc_s6[i])));
			end
		end
	end

	// stage 8: position step numerator
	logic             vld_s8;
	vec3_t            p_s8, v_s8, vn_s8;
	logic [2:0][49:0] num_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s8  <= p_s7;
			v_s8  <= v_s7;
			vn_s8 <= vn_s7;
			for (int i = 0; i < 3; i++) begin
				num_s8[i] <= $signed({1'b0, time_step_q}) * $signed(vn_s7[i]);
			end
		end
	end

	// stage 9: split numerator into sign and magnitude
	logic             vld_s9;
	pli_pos_t         pos_s9;
	logic [2:0][78:0] mag_s9;
	logic [30:0]      scale_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s9.pos <= p_s8;
			pos_s9.vel <= v_s8;
			pos_s9.vn  <= vn_s8;
			for (int i = 0; i < 3; i++) begin
				logic [49:0] ng;
				ng = 50'd0 - num_s8[i];
				pos_s9.neg[i] <= num_s8[i][49];
				mag_s9[i]     <= {31'd0, num_s8[i][49] ? ng[47:0] : num_s8[i][47:0]};
			end
			scale_s9 <= (sim_scale_q == 31'd0) ? 31'd1 : sim_scale_q;
		end
	end

	logic             pd_vld;
	logic [2:0][47:0] pq;
	pli_pos_t         pos_pd;

	pli_div3 #(
		.DEN_W  (31),
		.Q_W    (48),
		.SIDE_W ($bits(pli_pos_t))
	) u_pos_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s9),
		.num      (mag_s9),
		.den      (scale_s9),
		.side_in  (pos_s9),
		.out_vld  (pd_vld),
		.quo      (pq),
		.side_out (pos_pd)
	);

	// stage 10: new position and mean velocity into the output register
	pli_out_t out_s10;
	vec3_t    pn, mid;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [51:0] dq;
			logic signed [32:0] vs;
			dq = pos_pd.neg[i] ? (52'sd0 - $signed({4'd0, pq[i]})) : $signed({4'd0, pq[i]});
			pn[i]  = sat_fx(52'($signed(pos_pd.pos[i])) + dq);
			vs     = 33'($signed(pos_pd.vel[i])) + 33'($signed(pos_pd.vn[i]));
			mid[i] = vs[32:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s10 <= pd_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s10.new_pos_x <= pn[0];
			out_s10.new_pos_y <= pn[1];
			out_s10.new_pos_z <= pn[2];
			out_s10.new_vel_x <= pos_pd.vn[0];
			out_s10.new_vel_y <= pos_pd.vn[1];
			out_s10.new_vel_z <= pos_pd.vn[2];
			out_s10.mid_vel_x <= mid[0];
			out_s10.mid_vel_y <= mid[1];
			out_s10.mid_vel_z <= mid[2];
		end
	end

	assign out_valid = vld_s10;
	assign out_data  = out_s10;

	// a clamped force never exceeds the limit
	a_clamp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 && clamp_s5 |-> (mag32(fc_s5[0]) <= {1'b0, force_limit_q})
			&& (mag32(fc_s5[1]) <= {1'b0, force_limit_q})
			&& (mag32(fc_s5[2]) <= {1'b0, force_limit_q}))
		else $error("clamped force above limit");

	// clamping implies a nonzero magnitude root
	a_root_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		sq_vld && frc_sq.clamp |-> root != 32'd0)
		else $error("zero root on clamped item");

	// the clamp divide quotient fits its 31 bits
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && frc_s4.clamp |-> ((num_s4[0] >> 31) < 63'(den_s4))
			&& ((num_s4[1] >> 31) < 63'(den_s4))
			&& ((num_s4[2] >> 31) < 63'(den_s4)))
		else $error("clamp divide out of range");

endmodule

FILE: bench/particle_leapfrog_integrator_test.sv
// Self-checking bench for the particle leapfrog integrator: scoreboard class and drivers.
// Predicts every particle update in fixed point and compares each result transfer.
// Depends on pli_pkg and particle_leapfrog_integrator.
module particle_leapfrog_integrator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import pli_pkg::*;

	localparam int FRAC = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 140;
	localparam longint S32_HI = 64'sd2147483647;
	localparam longint S32_LO = -64'sd2147483648;
	localparam cfg_idx_t REG_SPARE_LO = 3'd5;
	localparam cfg_idx_t REG_SPARE_HI = 3'd7;

	// Holds register copies, predicts updates and checks result transfers
	class integ_scoreboard;
		longint dt, scale, limit, grav, smooth;
		pli_out_t pending[$];
		int mismatches;

		function new();
			dt = 66;
			scale = 65536;
			limit = 39321600;
			grav = -642253;
			smooth = 6554;
			mismatches = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [31:0] val);
			case (idx)
				REG_TIME_STEP:   dt = longint'(val & 32'h1FFFF);
				REG_SIM_SCALE:   scale = longint'(val & 32'h7FFFFFFF);
				REG_FORCE_LIMIT: limit = longint'(val & 32'h7FFFFFFF);
				REG_GRAVITY_Z:   grav = longint'(signed'(val));
				REG_SMOOTHING:   smooth = longint'(val & 32'h1FFFF);
				default: ;
			endcase
		endfunction

		function longint sat(longint x);
			if (x > S32_HI) return S32_HI;
			if (x < S32_LO) return S32_LO;
			return x;
		endfunction

		function longint unsigned root(longint unsigned n);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		// Work out the updated particle and queue it
		function void note_input(pli_in_t d);
			longint p[3], v[3], f[3], c[3], vn[3], pn[3], md[3];
			longint dv, dc, num, divisor;
			longint unsigned m2, lim2, s, a, q;
			pli_out_t r;
			p[0] = d.pos_x; p[1] = d.pos_y; p[2] = d.pos_z;
			v[0] = d.vel_x; v[1] = d.vel_y; v[2] = d.vel_z;
			f[0] = d.force_x; f[1] = d.force_y; f[2] = d.force_z;
			c[0] = d.corr_x; c[1] = d.corr_y; c[2] = d.corr_z;
			f[2] = sat(f[2] + grav);
			m2 = 0;
			for (int i = 0; i < 3; i++) begin
				a = (f[i] < 0) ? longint'(-f[i]) : f[i];
				m2 += a * a;
			end
			// clamp the force magnitude
			lim2 = longint'(limit) * longint'(limit);
			if (m2 > lim2) begin
				s = root(m2);
				if (s == 0) s = 1;
				for (int i = 0; i < 3; i++) begin
					a = (f[i] < 0) ? longint'(-f[i]) : f[i];
					q = a * limit / s;
					f[i] = (f[i] < 0) ? -longint'(q) : longint'(q);
				end
			end
			divisor = (scale == 0) ? 1 : scale;
			for (int i = 0; i < 3; i++) begin
				dv = (dt * f[i]) >>> FRAC;
				dc = (smooth * c[i]) >>> FRAC;
				vn[i] = sat(v[i] + dv + dc);
				num = dt * vn[i];
				pn[i] = sat(p[i] + num / divisor);
				md[i] = (v[i] + vn[i]) >>> 1;
			end
			r.new_pos_x = 32'(pn[0]); r.new_pos_y = 32'(pn[1]); r.new_pos_z = 32'(pn[2]);
			r.new_vel_x = 32'(vn[0]); r.new_vel_y = 32'(vn[1]); r.new_vel_z = 32'(vn[2]);
			r.mid_vel_x = 32'(md[0]); r.mid_vel_y = 32'(md[1]); r.mid_vel_z = 32'(md[2]);
			pending.push_back(r);
		endfunction

		function void check(pli_out_t got);
			pli_out_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch pos exp %h %h %h got %h %h %h", want.new_pos_x,
						want.new_pos_y, want.new_pos_z, got.new_pos_x, got.new_pos_y,
						got.new_pos_z);
					$display("  vel exp %h %h %h got %h %h %h", want.new_vel_x,
						want.new_vel_y, want.new_vel_z, got.new_vel_x, got.new_vel_y,
						got.new_vel_z);
					$display("  mid exp %h %h %h got %h %h %h", want.mid_vel_x,
						want.mid_vel_y, want.mid_vel_z, got.mid_vel_x, got.mid_vel_y,
						got.mid_vel_z);
				end
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	pli_in_t in_data;
	pli_out_t out_data;
	logic cfg_wr_en;
	cfg_idx_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	integ_scoreboard sb;
	bit quiet;
	bit hold_req;
	int cycles;

	particle_leapfrog_integrator uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("particle_leapfrog_integrator test failed");
				$finish;
			end
		end
	end

	// Receiver: check transfers, stall at random, hold off on request
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_ready = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check(out_data);
			if (hold_req && hold_left == 0) begin
				hold_left = 700;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 0;
			end else begin
				out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 15);
			end
		end
	end

	task automatic send(pli_in_t d);
		while (!quiet && $urandom_range(99) < 15) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(d);
	endtask

	task automatic cfg_write(cfg_idx_t idx, logic [31:0] val);
		cfg_wr_en <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	// Drop valid and let every expected result come out
	task automatic drain();
		in_valid <= 0;
		cfg_wr_en <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic pli_in_t noise_item();
		pli_in_t d;
		d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return d;
	endfunction

	function automatic fx_t span(int bits);
		return fx_t'($urandom_range((1 << bits) - 1)) - fx_t'(1 << (bits - 1));
	endfunction

	// Plausible particle with occasional large forces
	function automatic pli_in_t particle_item();
		pli_in_t d;
		int fb;
		fb = ($urandom_range(3) == 0) ? 30 : 24;
		d.pos_x = span(26); d.pos_y = span(26); d.pos_z = span(26);
		d.vel_x = span(22); d.vel_y = span(22); d.vel_z = span(22);
		d.force_x = span(fb); d.force_y = span(fb); d.force_z = span(fb);
		d.corr_x = span(20); d.corr_y = span(20); d.corr_z = span(20);
		return d;
	endfunction

	task automatic random_items(int n);
		for (int i = 0; i < n; i++)
			send(($urandom_range(99) < 75) ? particle_item() : noise_item());
	endtask

	initial begin : stimulus
		pli_in_t d;
		sb = new();
		quiet = 0;
		hold_req = 0;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_wr_en = 0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: field extremes under reset settings
		send('0);
		send({12{32'h7FFFFFFF}});
		send({12{32'h80000000}});
		send({12{32'hFFFFFFFF}});
		d = '0; d.force_x = 32'h7FFFFFFF; d.force_y = 32'h80000000; send(d);
		d = '0; d.force_z = 32'h80000000; send(d);
		d = '0; d.vel_x = 32'h7FFFFFFF; d.force_x = 32'h01000000; send(d);
		d = '0; d.vel_y = 32'h80000000; d.corr_y = 32'h80000000; send(d);
		d = '0; d.pos_z = 32'h7FFFFFF0; d.vel_z = 32'h7FFFFFFF; send(d);
		drain();

		// Extremes: step and weight of one, zero scale, zero limit, top gravity
		cfg_write(REG_TIME_STEP, 32'h00010000);
		cfg_write(REG_SIM_SCALE, 32'h0);
		cfg_write(REG_FORCE_LIMIT, 32'h0);
		cfg_write(REG_GRAVITY_Z, 32'h7FFFFFFF);
		cfg_write(REG_SMOOTHING, 32'h00010000);
		cfg_write(REG_SPARE_LO, 32'h12345678);
		cfg_write(REG_SPARE_HI, 32'hFFFFFFFF);
		drain();
		send('0);
		send({12{32'h7FFFFFFF}});
		send({12{32'h80000000}});
		d = '0; d.force_x = 32'h00000001; d.vel_x = 32'h40000000; send(d);
		d = '0; d.corr_x = 32'h7FFFFFFF; d.pos_x = 32'h80000000; send(d);
		random_items(150);
		drain();

		// Wide values masked, lowest gravity, then zero step and weight with the smallest nonzero scale
		cfg_write(REG_TIME_STEP, 32'hFFFFFFFF);
		cfg_write(REG_SIM_SCALE, 32'hFFFFFFFF);
		cfg_write(REG_FORCE_LIMIT, 32'hFFFFFFFF);
		cfg_write(REG_GRAVITY_Z, 32'h80000000);
		cfg_write(REG_SMOOTHING, 32'hFFFFFFFF);
		drain();
		send({12{32'h80000000}});
		send({12{32'h7FFFFFFF}});
		random_items(100);
		drain();
		cfg_write(REG_TIME_STEP, 32'h0);
		cfg_write(REG_SMOOTHING, 32'h0);
		cfg_write(REG_SIM_SCALE, 32'h1);
		drain();
		send({12{32'h7FFFFFFF}});
		random_items(80);
		drain();

		// Middling settings, no idling, then a long receiver hold
		cfg_write(REG_TIME_STEP, 32'd655);
		cfg_write(REG_SIM_SCALE, 32'd32768);
		cfg_write(REG_FORCE_LIMIT, 32'd6553600);
		cfg_write(REG_GRAVITY_Z, -32'sd642253);
		cfg_write(REG_SMOOTHING, 32'd3277);
		drain();
		quiet = 1;
		random_items(150);
		hold_req = 1;
		random_items(200);
		quiet = 0;
		drain();

		// Random settings
		for (int k = 0; k < 4; k++) begin
			cfg_write(REG_TIME_STEP, $urandom_range(65536));
			cfg_write(REG_SIM_SCALE, $urandom);
			cfg_write(REG_FORCE_LIMIT, $urandom >> $urandom_range(31));
			cfg_write(REG_GRAVITY_Z, $urandom);
			cfg_write(REG_SMOOTHING, $urandom_range(65536));
			drain();
			random_items(55);
			drain();
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("particle_leapfrog_integrator test passed");
		else
			$display("particle_leapfrog_integrator test failed");
		$finish;
	end
endmodule
